// File: sv/lpcd_pkg.sv
// Package with the shared types, codes and CRC function of the length-prefixed CRC deframer.
`default_nettype none
package lpcd_pkg;

  localparam logic [7:0] TERM_BYTE = 8'h03;
  localparam logic [7:0] TYPE_LEN1 = 8'd2;
  localparam logic [7:0] TYPE_LEN2 = 8'd3;
  localparam logic [7:0] TYPE_LEN3 = 8'd4;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [23:0] MAX_LEN_RESET = 24'd512;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_TERM  = 3'd3,
    ST_CRC_ERROR = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic [5:0] {
    PH_TYPE   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_CRC_HI = 6'b001000,
    PH_CRC_LO = 6'b010000,
    PH_TERM   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        has;
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     frame_status;
    logic [23:0] frame_length;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/lpcd_if.sv
// Stream interfaces for received bytes and for deframer results.
`default_nettype none
interface lpcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpcd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_status;
  logic [23:0] frame_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_status, output frame_length, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input frame_status, input frame_length, output ready);
endinterface
`default_nettype wire

// File: sv/lpcd_parse.sv
// Frame parser state and per-byte next-state and result logic.
`default_nettype none
module lpcd_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [7:0]       data,
  input  wire logic [23:0]      max_len,
  output lpcd_pkg::result_t     res
);
  import lpcd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  left, left_next;
  logic [23:0] decl, decl_next;
  logic [23:0] seen, seen_next;
  logic [15:0] crc, crc_next;
  logic [15:0] rcrc, rcrc_next;

  always_comb begin
    phase_next = phase;
    left_next  = left;
    decl_next  = decl;
    seen_next  = seen;
    crc_next   = crc;
    rcrc_next  = rcrc;
    res.has          = 1'b0;
    res.kind         = KIND_STATUS;
    res.payload_byte = 8'h00;
    res.frame_status = ST_OK;
    res.frame_length = decl;
    unique case (phase)
      PH_LEN: begin
        decl_next = {decl[15:0], data};
        left_next = left - 2'd1;
        if (left_next == 2'd0) begin
          if (decl_next > max_len) begin
            res.has          = 1'b1;
            res.frame_status = ST_TOO_LONG;
            res.frame_length = decl_next;
            phase_next       = PH_TYPE;
          end else begin
            seen_next  = 24'd0;
            crc_next   = 16'h0000;
            phase_next = (decl_next == 24'd0) ? PH_CRC_HI : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_next  = crc_step(crc, data);
        seen_next = seen + 24'd1;
        if (seen_next == decl) begin
          phase_next = PH_CRC_HI;
        end
        res.has          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data;
      end
      PH_CRC_HI: begin
        rcrc_next  = {data, 8'h00};
        phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rcrc_next  = {rcrc[15:8], data};
        phase_next = PH_TERM;
      end
      PH_TERM: begin
        res.has    = 1'b1;
        phase_next = PH_TYPE;
        if (data != TERM_BYTE) begin
          res.frame_status = ST_BAD_TERM;
        end else if (crc != rcrc) begin
          res.frame_status = ST_CRC_ERROR;
        end
      end
      default: begin
        if (data == TYPE_LEN1 || data == TYPE_LEN2 || data == TYPE_LEN3) begin
          left_next  = data[1:0] - 2'd1;
          decl_next  = 24'd0;
          phase_next = PH_LEN;
        end else begin
          res.has          = 1'b1;
          res.frame_status = ST_BAD_TYPE;
          res.frame_length = 24'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      left  <= 2'd0;
      decl  <= 24'd0;
      seen  <= 24'd0;
      crc   <= 16'h0000;
      rcrc  <= 16'h0000;
    end else if (go) begin
      phase <= phase_next;
      left  <= left_next;
      decl  <= decl_next;
      seen  <= seen_next;
      crc   <= crc_next;
      rcrc  <= rcrc_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/length_prefixed_crc_deframer_top.sv
// Top level of the length-prefixed CRC-16/XMODEM frame deframer.
// A byte accepted into the input register is parsed from it combinationally and its result is
// loaded into the output register that drives result valid; a held unaccepted result stalls both.
// Throughput: one byte per cycle when not stalled, set by the single-stage parse and CRC update.
// Reset (rst, synchronous): parser waits for a type byte, max_payload_len returns to 512.
`default_nettype none
module length_prefixed_crc_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  lpcd_byte_if.sink        stream,
  lpcd_result_if.source    result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lpcd_pkg::*;

  logic        in_v;
  logic [7:0]  in_b;
  logic        out_v;
  result_t     out_q;
  result_t     res;
  logic        go;
  logic [23:0] max_len;

  lpcd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .data    (in_b),
    .max_len (max_len),
    .res     (res)
  );

  assign go           = in_v && (!out_v || result.ready || !res.has);
  assign stream.ready = !in_v || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_v <= 1'b1;
    end else if (go) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_b <= stream.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (go && res.has) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.has) begin
      out_q <= res;
    end
  end

  assign result.valid        = out_v;
  assign result.result_kind  = out_q.kind;
  assign result.payload_byte = out_q.payload_byte;
  assign result.frame_status = out_q.frame_status;
  assign result.frame_length = out_q.frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_len <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {8'h00, max_len} : 32'h0000_0000;

endmodule
`default_nettype wire

// File: tb/length_prefixed_crc_deframer_top_test.sv
// Self-checking testbench for the length-prefixed CRC-16/XMODEM deframer.
`timescale 1ns / 100ps
`default_nettype none
module length_prefixed_crc_deframer_top_test;
  import lpcd_pkg::*;

  localparam logic [2:0] REG_MAX_LEN = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_SETTING = 340;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    status_t     status;
    logic [23:0] length;
  } deframer_result_t;

  class deframer_scoreboard;
    logic [23:0] max_len;
    phase_t phase;
    logic [1:0] len_left;
    logic [23:0] decl_len;
    logic [23:0] seen;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    deframer_result_t expected_q[$];
    int unsigned errors;

    function new();
      max_len = MAX_LEN_RESET;
      phase = PH_TYPE;
      len_left = '0;
      decl_len = '0;
      seen = '0;
      crc = '0;
      rx_crc = '0;
      errors = 0;
    endfunction

    static function logic [15:0] crc_next(logic [15:0] crc_in, logic [7:0] data);
      logic [15:0] r;
      logic fb;
      r = crc_in;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ data[i];
        r = {r[14:0], 1'b0};
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void push_result(kind_t k, logic [7:0] d, status_t s, logic [23:0] l);
      deframer_result_t r;
      r.kind = k;
      r.data = d;
      r.status = s;
      r.length = l;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void set_max_len(logic [23:0] value);
      max_len = value;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        PH_LEN: begin
          decl_len = {decl_len[15:0], b};
          len_left = len_left - 2'd1;
          if (len_left == 2'd0) begin
            if (decl_len > max_len) begin
              push_result(KIND_STATUS, 8'h00, ST_TOO_LONG, decl_len);
              phase = PH_TYPE;
            end else begin
              seen = '0;
              crc = '0;
              phase = (decl_len == 24'd0) ? PH_CRC_HI : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          crc = crc_next(crc, b);
          seen = seen + 24'd1;
          if (seen == decl_len) begin
            phase = PH_CRC_HI;
          end
          push_result(KIND_PAYLOAD, b, ST_OK, decl_len);
        end
        PH_CRC_HI: begin
          rx_crc = {b, 8'h00};
          phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc[7:0] = b;
          phase = PH_TERM;
        end
        PH_TERM: begin
          if (b != TERM_BYTE) begin
            push_result(KIND_STATUS, 8'h00, ST_BAD_TERM, decl_len);
          end else if (crc != rx_crc) begin
            push_result(KIND_STATUS, 8'h00, ST_CRC_ERROR, decl_len);
          end else begin
            push_result(KIND_STATUS, 8'h00, ST_OK, decl_len);
          end
          phase = PH_TYPE;
        end
        default: begin
          if (b == TYPE_LEN1 || b == TYPE_LEN2 || b == TYPE_LEN3) begin
            len_left = b[1:0] - 2'd1;
            decl_len = '0;
            phase = PH_LEN;
          end else begin
            push_result(KIND_STATUS, 8'h00, ST_BAD_TYPE, 24'd0);
            phase = PH_TYPE;
          end
        end
      endcase
    endfunction

    task check_result(logic kind, logic [7:0] data, logic [2:0] status,
                      logic [23:0] length);
      deframer_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d status=%0d", kind, status));
        return;
      end
      e = expected_q.pop_front();
      if (kind != e.kind) begin
        report_mismatch($sformatf("result_kind %0d, expected %0d", kind, e.kind));
      end
      if (data != e.data) begin
        report_mismatch($sformatf("payload_byte %02h, expected %02h", data, e.data));
      end
      if (status != e.status) begin
        report_mismatch($sformatf("frame_status %0d, expected %0d", status, e.status));
      end
      if (length != e.length) begin
        report_mismatch($sformatf("frame_length %0d, expected %0d", length, e.length));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lpcd_byte_if stream_if ();
  lpcd_result_if result_if ();

  length_prefixed_crc_deframer_top u_top (
    .clk(clk),
    .rst(rst),
    .stream(stream_if),
    .result(result_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  deframer_scoreboard sb = new();
  bit calm = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("length_prefixed_crc_deframer_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_if.ready = calm || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (stream_if.valid && stream_if.ready) begin
        sb.note_byte(stream_if.in_byte);
      end
      if (result_if.valid && result_if.ready) begin
        sb.check_result(result_if.result_kind, result_if.payload_byte,
                        result_if.frame_status, result_if.frame_length);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 25) begin
      stream_if.valid = 1'b0;
      @(negedge clk);
    end
    stream_if.valid = 1'b1;
    stream_if.in_byte = b;
    @(posedge clk);
    while (!stream_if.ready) begin
      @(posedge clk);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_max_len();
    logic [31:0] rdata;
    apb_access(1'b0, REG_MAX_LEN, 32'd0, rdata);
    if (rdata[23:0] != sb.max_len) begin
      sb.report_mismatch($sformatf("max_payload_len reads %0d, expected %0d",
                                   rdata[23:0], sb.max_len));
    end
  endtask

  task automatic write_max_len(input logic [23:0] value);
    logic [31:0] unused;
    apb_access(1'b1, REG_MAX_LEN, {8'h00, value}, unused);
    sb.set_max_len(value);
    check_max_len();
  endtask

  task automatic settle();
    stream_if.valid = 1'b0;
    while (sb.outstanding() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame();
    int unsigned flavor;
    int unsigned plen;
    int unsigned nbytes;
    int unsigned span;
    logic [23:0] dlen;
    logic [15:0] fcs;
    logic [7:0] b;
    logic [7:0] term;
    flavor = $urandom_range(99);
    if (flavor < 8) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b >= TYPE_LEN1 && b <= TYPE_LEN3) begin
          b = b ^ 8'h80;
        end
        send_byte(b);
      end
      return;
    end
    if (flavor < 14 && sb.max_len != 24'hFFFFFF) begin
      span = 32'hFFFFFF - sb.max_len;
      dlen = ($urandom_range(1) == 0) ? sb.max_len + 24'd1
                                      : 24'(sb.max_len + 1 + ($urandom % span));
    end else begin
      plen = ($urandom_range(99) < 5) ? $urandom_range(300) : $urandom_range(24);
      if (plen > sb.max_len) begin
        plen = sb.max_len;
      end
      dlen = 24'(plen);
    end
    nbytes = (dlen < 24'd256) ? 1 : (dlen < 24'd65536) ? 2 : 3;
    if ($urandom_range(99) < 30) begin
      nbytes = $urandom_range(3, nbytes);
    end
    send_byte(TYPE_LEN1 + 8'(nbytes - 1));
    for (int i = int'(nbytes) - 1; i >= 0; i--) begin
      send_byte(8'(dlen >> (8 * i)));
    end
    if (dlen > sb.max_len) begin
      return;
    end
    fcs = '0;
    repeat (dlen) begin
      b = 8'($urandom);
      fcs = deframer_scoreboard::crc_next(fcs, b);
      send_byte(b);
    end
    if (flavor >= 14 && flavor < 26) begin
      fcs = fcs ^ (16'h0001 << $urandom_range(15));
    end
    term = TERM_BYTE;
    if (flavor >= 22 && flavor < 30) begin
      term = 8'($urandom);
      if (term == TERM_BYTE) begin
        term = ~term;
      end
    end
    send_byte(fcs[15:8]);
    send_byte(fcs[7:0]);
    send_byte(term);
  endtask

  initial begin
    logic [7:0] opening [23];
    logic [23:0] limits [4];
    opening = '{8'hFF,
                TYPE_LEN1, 8'h00, 8'h00, 8'h00, TERM_BYTE,
                TYPE_LEN3, 8'h00, 8'h02, 8'h01,
                TYPE_LEN2, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00,
                TYPE_LEN1, 8'h01, 8'h00, 8'h00, 8'h01, TERM_BYTE};
    limits = '{24'd0, 24'hFFFFFF, 24'($urandom_range(2, 40)), 24'd1};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    stream_if.valid = 1'b0;
    stream_if.in_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_max_len();
    foreach (opening[i]) begin
      send_byte(opening[i]);
    end
    for (int p = 0; p <= 4; p++) begin
      if (p > 0) begin
        settle();
        write_max_len(limits[p - 1]);
      end
      calm = (p == 2);
      while (items_sent < (p + 1) * ITEMS_PER_SETTING) begin
        send_frame();
      end
    end
    calm = 1'b0;
    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("length_prefixed_crc_deframer_top verification clean");
    end else begin
      $display("length_prefixed_crc_deframer_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
